FILE: rtl/baa_pkg.sv
// Shared types and codes for the bump arena allocator.
package baa_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DATA_W    = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 2'd1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_CALLOC  = 2'd1,
    OP_RESET   = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOSETUP = 3'd1,
    ST_ZERO    = 3'd2,
    ST_ALIGN   = 3'd3,
    ST_OVF     = 3'd4,
    ST_ROOM    = 3'd5,
    ST_MARK    = 3'd6
  } status_t;

  // Request after the state-independent checks
  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] size;        // request size, or count*size for calloc
    logic              pre_err;     // calloc failed before the arena is looked at
    status_t           pre_status;
    logic [DATA_W-1:0] align_mask;  // effective alignment minus one
    logic              align_bad;
    logic [DATA_W-1:0] mark;
  } prep_t;

  // Result word plus the next arena state
  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] address;
    logic [DATA_W-1:0] used;
    logic [DATA_W-1:0] remaining;
    logic [DATA_W-1:0] peak;
    logic [DATA_W-1:0] offset_nxt;
    logic [DATA_W-1:0] hw_nxt;
  } result_t;

endpackage

FILE: rtl/bump_arena_allocator_core.sv
// Top level of the bump-pointer arena allocator.
//
// Usage:
//   cfg_*  plain write port. Index 0 is the arena base address, index 1 the
//          capacity in bytes; either write clears the offset and the peak.
//          Other indexes are ignored. Write only while the block is idle.
//   in_*   request words (valid/ready): alloc, calloc, reset or release.
//   out_*  one result word per request (valid/ready): status, address,
//          used, remaining and peak.
// Pipeline: input register -> calloc multiply and alignment checks ->
//   arena step and result register. One request per cycle sustained
//   while out_ready is high. The running offset is read and written
//   only in the last stage, so back-to-back requests see each other's
//   effect with no bubble.
// Each stage holds its word while the next stage is full; in_ready stays
// high while any stage is empty, so requests keep flowing while a result
// waits for out_ready.
// Reset (rst_n low, synchronous) empties the pipeline and clears base,
// capacity, offset and peak: the arena is not set up until configured.
module bump_arena_allocator_core
  import baa_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = 32,
  parameter int unsigned MIN_ALIGN  = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_op,
  input  logic [DATA_W-1:0]    in_size,
  input  logic [DATA_W-1:0]    in_count,
  input  logic [DATA_W-1:0]    in_align,
  input  logic [DATA_W-1:0]    in_mark_offset,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [DATA_W-1:0]    out_address,
  output logic [DATA_W-1:0]    out_used,
  output logic [DATA_W-1:0]    out_remaining,
  output logic [DATA_W-1:0]    out_peak
);

  // config and arena state
  logic [DATA_W-1:0] base_r, cap_r, offset_r, hw_r;

  // stage 0: raw request
  logic              s0_valid_r;
  op_t               s0_op_r;
  logic [DATA_W-1:0] s0_size_r, s0_count_r, s0_align_r, s0_mark_r;

  // stage 1: prepared request
  logic  s1_valid_r;
  prep_t s1_req_r;
  prep_t prep;

  // output stage
  logic    out_valid_r;
  result_t out_r;
  result_t res;

  logic o_free, s1_free, s0_free, s1_move, s0_move, in_acc;

  assign o_free  = !out_valid_r || out_ready;
  assign s1_free = !s1_valid_r || o_free;
  assign s0_free = !s0_valid_r || s1_free;
  assign s1_move = s1_valid_r && o_free;
  assign s0_move = s0_valid_r && s1_free;
  assign in_ready = s0_free;
  assign in_acc   = in_valid && s0_free;

  baa_req_prep #(
    .MIN_ALIGN(MIN_ALIGN)
  ) u_prep (
    .op    (s0_op_r),
    .size  (s0_size_r),
    .count (s0_count_r),
    .align (s0_align_r),
    .mark  (s0_mark_r),
    .prep  (prep)
  );

  baa_alloc_core #(
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_core (
    .req          (s1_req_r),
    .base_address (base_r),
    .capacity     (cap_r),
    .offset       (offset_r),
    .high_water   (hw_r),
    .res          (res)
  );

  // handshake flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s0_free)  s0_valid_r  <= in_valid;
      if (s1_free)  s1_valid_r  <= s0_valid_r;
      if (o_free)   out_valid_r <= s1_valid_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_op_r    <= op_t'(in_op);
      s0_size_r  <= in_size;
      s0_count_r <= in_count;
      s0_align_r <= in_align;
      s0_mark_r  <= in_mark_offset;
    end
    if (s0_move) s1_req_r <= prep;
    if (s1_move) out_r    <= res;
  end

  // configuration and arena state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      cap_r    <= '0;
      offset_r <= '0;
      hw_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_ADDRESS: begin
          base_r   <= cfg_wdata;
          offset_r <= '0;
          hw_r     <= '0;
        end
        REG_CAPACITY: begin
          cap_r    <= cfg_wdata;
          offset_r <= '0;
          hw_r     <= '0;
        end
        default: ;  // unmapped index, write dropped
      endcase
    end else if (s1_move) begin
      offset_r <= res.offset_nxt;
      hw_r     <= res.hw_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_r.status;
  assign out_address   = out_r.address;
  assign out_used      = out_r.used;
  assign out_remaining = out_r.remaining;
  assign out_peak      = out_r.peak;

endmodule

FILE: rtl/baa_req_prep.sv
// Request front end: calloc product and alignment checks.
module baa_req_prep
  import baa_pkg::*;
#(
  parameter int unsigned MIN_ALIGN = 4
) (
  input  op_t               op,
  input  logic [DATA_W-1:0] size,
  input  logic [DATA_W-1:0] count,
  input  logic [DATA_W-1:0] align,
  input  logic [DATA_W-1:0] mark,
  output prep_t             prep
);

  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]   al_eff;

  assign prod   = (2*DATA_W)'(count) * (2*DATA_W)'(size);
  assign al_eff = (align < DATA_W'(MIN_ALIGN)) ? DATA_W'(MIN_ALIGN) : align;

  always_comb begin
    prep.op         = op;
    prep.size       = size;
    prep.pre_err    = 1'b0;
    prep.pre_status = ST_OK;
    prep.align_mask = al_eff - DATA_W'(1);
    prep.align_bad  = (al_eff & (al_eff - DATA_W'(1))) != '0;
    prep.mark       = mark;
    if (op == OP_CALLOC) begin
      prep.size = prod[DATA_W-1:0];
      if (count == '0 || size == '0) begin
        prep.pre_err    = 1'b1;
        prep.pre_status = ST_ZERO;
      end else if (|prod[2*DATA_W-1:DATA_W]) begin
        prep.pre_err    = 1'b1;
        prep.pre_status = ST_OVF;
      end
    end
  end

endmodule

FILE: rtl/baa_alloc_core.sv
// Arena step: bump, reset or release against the running offset.
module baa_alloc_core
  import baa_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  prep_t             req,
  input  logic [DATA_W-1:0] base_address,
  input  logic [DATA_W-1:0] capacity,
  input  logic [DATA_W-1:0] offset,
  input  logic [DATA_W-1:0] high_water,
  output result_t           res
);

  localparam int unsigned AW = ADDR_WIDTH;

  logic [AW-1:0]     base_a, cur_a, mask_a, aligned_a, aoff_a;
  logic [63:0]       aoff_w, aligned_w;
  logic [DATA_W:0]   end_w;
  logic              setup, wrap, aoff_hi;
  logic [DATA_W-1:0] off_n, hw_n;
  status_t           st;
  logic [DATA_W-1:0] addr;

  assign base_a    = AW'(base_address);
  assign setup     = (capacity != '0) && (base_a != '0);
  assign cur_a     = base_a + AW'(offset);
  assign mask_a    = AW'(req.align_mask);
  assign aligned_a = (cur_a + mask_a) & ~mask_a;
  assign wrap      = aligned_a < base_a;
  assign aoff_a    = aligned_a - base_a;
  assign aoff_w    = 64'(aoff_a);
  assign aligned_w = 64'(aligned_a);
  assign aoff_hi   = |aoff_w[63:DATA_W];
  assign end_w     = {1'b0, aoff_w[DATA_W-1:0]} + {1'b0, req.size};

  always_comb begin
    st    = ST_OK;
    addr  = '0;
    off_n = offset;
    hw_n  = high_water;
    unique case (req.op)
      OP_ALLOC, OP_CALLOC: begin
        if (req.pre_err)                 st = req.pre_status;
        else if (!setup)                 st = ST_NOSETUP;
        else if (req.size == '0)         st = ST_ZERO;
        else if (req.align_bad)          st = ST_ALIGN;
        else if (wrap || aoff_hi || end_w[DATA_W]) st = ST_OVF;
        else if (end_w[DATA_W-1:0] > capacity)     st = ST_ROOM;
        else begin
          off_n = end_w[DATA_W-1:0];
          addr  = aligned_w[DATA_W-1:0];
          if (end_w[DATA_W-1:0] > high_water) hw_n = end_w[DATA_W-1:0];
        end
      end
      OP_RESET: begin
        if (!setup) st = ST_NOSETUP;
        else        off_n = '0;
      end
      OP_RELEASE: begin
        if (!setup)                st = ST_NOSETUP;
        else if (req.mark > offset) st = ST_MARK;
        else                       off_n = req.mark;
      end
      default: st = ST_OK;
    endcase
  end

  always_comb begin
    res.status     = st;
    res.address    = addr;
    res.used       = off_n;
    res.remaining  = (capacity >= off_n) ? (capacity - off_n) : '0;
    res.peak       = hw_n;
    res.offset_nxt = off_n;
    res.hw_nxt     = hw_n;
  end

endmodule
